// File: hdl/tuvm_pkg.sv
// ----------------------------------------------------------------------------
// tuvm_pkg
// Shared constants and helpers for the texture coordinate matrix setup block.
// ----------------------------------------------------------------------------
package tuvm_pkg;

  // Default number of fraction bits of the fixed point format.
  localparam int unsigned FracBitsDef = 16;

  // Quotient bits produced by the divider below the saturation point.
  localparam int unsigned QBits = 31;

  // Width of the determinant magnitude (divisor).
  localparam int unsigned DenW = 64;

  // Registers through the divider: entry register, one register per quotient bit, output.
  localparam int unsigned LatDiv = QBits + 2;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CfgFixMode   = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgInvScaleX = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgInvScaleY = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgOffsetU   = 4'd3;
  localparam logic [CfgIdxW-1:0] CfgOffsetV   = 4'd4;
  localparam logic [CfgIdxW-1:0] CfgRotEnable = 4'd5;
  localparam logic [CfgIdxW-1:0] CfgRotCos    = 4'd6;
  localparam logic [CfgIdxW-1:0] CfgRotSin    = 4'd7;

  // Saturation limits of a 32-bit signed value.
  localparam logic signed [31:0] QMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;

  // Clamp a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    if (v > 72'sd2147483647) begin
      return QMax;
    end else if (v < -72'sd2147483648) begin
      return QMin;
    end
    return 32'(v);
  endfunction

endpackage

// File: hdl/tuvm_div.sv
// ----------------------------------------------------------------------------
// tuvm_div
// Pipelined restoring divider, one quotient bit per stage, signed saturated.
// ----------------------------------------------------------------------------
module tuvm_div
  import tuvm_pkg::*;
#(
  parameter int unsigned NUM_W = 96
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [NUM_W-1:0]        num_i,
  input  logic [DenW-1:0]         den_i,
  input  logic                    neg_i,
  output logic signed [31:0]      quo_o
);

  // Working width holds both the numerator and the divisor shifted to bit 31.
  localparam int unsigned XW = (NUM_W > DenW + QBits) ? NUM_W : DenW + QBits;

  logic [XW-1:0]    rem_q [0:QBits];
  logic [DenW-1:0]  den_q [0:QBits];
  logic [QBits-1:0] quo_q [0:QBits];
  logic             neg_q [0:QBits];
  logic             sat_q [0:QBits];
  logic [QBits-1:0] quo_last;

  // Entry stage: a quotient of 2^31 or more saturates either sign.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= XW'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      neg_q[0] <= neg_i;
      sat_q[0] <= (XW'(num_i) >= (XW'(den_i) << QBits));
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 0; k < QBits; k++) begin : g_step
    localparam int unsigned Sh = QBits - 1 - k;
    logic [XW-1:0] dsh;
    logic          take;
    assign dsh  = XW'(den_q[k]) << Sh;
    assign take = (rem_q[k] >= dsh);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= take ? (rem_q[k] - dsh) : rem_q[k];
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= {quo_q[k][QBits-2:0], take};
        neg_q[k+1] <= neg_q[k];
        sat_q[k+1] <= sat_q[k];
      end
    end
  end

  assign quo_last = quo_q[QBits];

  // Apply sign and saturation.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (sat_q[QBits]) begin
        quo_o <= neg_q[QBits] ? QMin : QMax;
      end else if (neg_q[QBits]) begin
        quo_o <= -$signed({1'b0, quo_last});
      end else begin
        quo_o <= $signed({1'b0, quo_last});
      end
    end
  end

endmodule

// File: hdl/texture_uv_matrix_setup.sv
// ----------------------------------------------------------------------------
// texture_uv_matrix_setup
// Forms texture u/v coefficients from a shape's affine matrix and pivots.
// ----------------------------------------------------------------------------
// Usage:
// A request on the input channel carries one affine matrix (mat_a..mat_f)
// and the screen and local pivots. For every request the block returns one
// result on the output channel: six Q coefficients and the singular flag.
// The pipeline takes one request per cycle unless the output is stalled.
// The depth is set by the six parallel matrix inverse dividers, which
// resolve one quotient bit per stage (33 stages), plus the product,
// scale and rotation stages around them.
// The receiver stalls the output with out_stall_i; while a result is held,
// the whole pipeline freezes and in_stall_o is raised, so nothing is lost
// or repeated. Configuration is written through cfg_we_i/cfg_idx_i/
// cfg_wdata_i while no request is in flight; indexes past the last
// register are ignored. Reset empties the pipeline and loads the register
// defaults (unit scale, no offset, no rotation, pivot mode).
// ----------------------------------------------------------------------------
module texture_uv_matrix_setup
  import tuvm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  mat_a_i,
  input  logic signed [31:0]  mat_b_i,
  input  logic signed [31:0]  mat_c_i,
  input  logic signed [31:0]  mat_d_i,
  input  logic signed [31:0]  mat_e_i,
  input  logic signed [31:0]  mat_f_i,
  input  logic signed [31:0]  screen_pivot_x_i,
  input  logic signed [31:0]  screen_pivot_y_i,
  input  logic signed [31:0]  local_pivot_x_i,
  input  logic signed [31:0]  local_pivot_y_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  u_coef_x_o,
  output logic signed [31:0]  u_coef_y_o,
  output logic signed [31:0]  u_const_o,
  output logic signed [31:0]  v_coef_x_o,
  output logic signed [31:0]  v_coef_y_o,
  output logic signed [31:0]  v_const_o,
  output logic                singular_o
);

  localparam int unsigned NumW = DenW + 2 * FRAC_BITS;
  localparam int unsigned NStg = LatDiv + 9;
  localparam logic [63:0] DetLimit = (64'd1 << (2 * FRAC_BITS)) / 64'd10000;
  localparam logic signed [31:0] One  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [31:0] Half = 32'sd1 <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic               sing;
    logic signed [31:0] pdu;
    logic signed [31:0] pdv;
  } side_t;

  // Configuration registers.
  logic               fix_mode_q, rot_en_q;
  logic signed [31:0] isx_q, isy_q, ofs_u_q, ofs_v_q;
  logic signed [17:0] rcos_q, rsin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fix_mode_q <= 1'b0;
      isx_q      <= One;
      isy_q      <= One;
      ofs_u_q    <= '0;
      ofs_v_q    <= '0;
      rot_en_q   <= 1'b0;
      rcos_q     <= 18'(One);
      rsin_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFixMode:   fix_mode_q <= cfg_wdata_i[0];
        CfgInvScaleX: isx_q      <= $signed(cfg_wdata_i);
        CfgInvScaleY: isy_q      <= $signed(cfg_wdata_i);
        CfgOffsetU:   ofs_u_q    <= $signed(cfg_wdata_i);
        CfgOffsetV:   ofs_v_q    <= $signed(cfg_wdata_i);
        CfgRotEnable: rot_en_q   <= cfg_wdata_i[0];
        CfgRotCos:    rcos_q     <= $signed(cfg_wdata_i[17:0]);
        CfgRotSin:    rsin_q     <= $signed(cfg_wdata_i[17:0]);
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline freezes while the output is held.
  logic            en;
  logic [NStg-1:0] vld_q;

  assign en         = !(vld_q[NStg-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[NStg-1];

  // Stage 0: capture the request and form the pivot translation.
  logic signed [31:0] a0_q, b0_q, c0_q, d0_q, e0_q, f0_q, pdu0_q, pdv0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_q   <= mat_a_i;
      b0_q   <= mat_b_i;
      c0_q   <= mat_c_i;
      d0_q   <= mat_d_i;
      e0_q   <= mat_e_i;
      f0_q   <= mat_f_i;
      pdu0_q <= sat32(72'(local_pivot_x_i) - 72'(screen_pivot_x_i));
      pdv0_q <= sat32(72'(local_pivot_y_i) - 72'(screen_pivot_y_i));
    end
  end

  // Stage 1: the six exact products.
  logic signed [63:0] p_ad_q, p_bc_q, p_cf_q, p_de_q, p_be_q, p_af_q;
  logic signed [31:0] a1_q, b1_q, c1_q, d1_q, pdu1_q, pdv1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_ad_q <= a0_q * d0_q;
      p_bc_q <= b0_q * c0_q;
      p_cf_q <= c0_q * f0_q;
      p_de_q <= d0_q * e0_q;
      p_be_q <= b0_q * e0_q;
      p_af_q <= a0_q * f0_q;
      a1_q   <= a0_q;
      b1_q   <= b0_q;
      c1_q   <= c0_q;
      d1_q   <= d0_q;
      pdu1_q <= pdu0_q;
      pdv1_q <= pdv0_q;
    end
  end

  // Stage 2: determinant and translation numerators as sign and magnitude.
  logic signed [64:0] det, nu, nv;
  logic [63:0]        dm_q, num_u_q, num_v_q;
  logic               dn_q, nn_u_q, nn_v_q;
  logic signed [31:0] a2_q, b2_q, c2_q, d2_q, pdu2_q, pdv2_q;

  assign det = 65'(p_ad_q) - 65'(p_bc_q);
  assign nu  = 65'(p_cf_q) - 65'(p_de_q);
  assign nv  = 65'(p_be_q) - 65'(p_af_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dm_q    <= 64'(det[64] ? -det : det);
      dn_q    <= det[64];
      num_u_q <= 64'(nu[64] ? -nu : nu);
      nn_u_q  <= nu[64];
      num_v_q <= 64'(nv[64] ? -nv : nv);
      nn_v_q  <= nv[64];
      a2_q    <= a1_q;
      b2_q    <= b1_q;
      c2_q    <= c1_q;
      d2_q    <= d1_q;
      pdu2_q  <= pdu1_q;
      pdv2_q  <= pdv1_q;
    end
  end

  // Divider operands for the six inverse entries.
  logic [NumW-1:0]    div_num [0:5];
  logic               div_neg [0:5];
  logic signed [31:0] div_quo [0:5];
  logic [31:0]        abs_a, abs_b, abs_c, abs_d;

  assign abs_a = a2_q[31] ? 32'(-33'(a2_q)) : 32'(a2_q);
  assign abs_b = b2_q[31] ? 32'(-33'(b2_q)) : 32'(b2_q);
  assign abs_c = c2_q[31] ? 32'(-33'(c2_q)) : 32'(c2_q);
  assign abs_d = d2_q[31] ? 32'(-33'(d2_q)) : 32'(d2_q);

  always_comb begin
    div_num[0] = NumW'(abs_d) << (2 * FRAC_BITS);
    div_neg[0] = d2_q[31] != dn_q;
    div_num[1] = NumW'(abs_c) << (2 * FRAC_BITS);
    div_neg[1] = (!c2_q[31] && (c2_q != '0)) != dn_q;
    div_num[2] = NumW'(num_u_q) << FRAC_BITS;
    div_neg[2] = nn_u_q != dn_q;
    div_num[3] = NumW'(abs_b) << (2 * FRAC_BITS);
    div_neg[3] = (!b2_q[31] && (b2_q != '0)) != dn_q;
    div_num[4] = NumW'(abs_a) << (2 * FRAC_BITS);
    div_neg[4] = a2_q[31] != dn_q;
    div_num[5] = NumW'(num_v_q) << FRAC_BITS;
    div_neg[5] = nn_v_q != dn_q;
  end

  for (genvar k = 0; k < 6; k++) begin : g_div
    tuvm_div #(
      .NUM_W (NumW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (div_num[k]),
      .den_i (dm_q),
      .neg_i (div_neg[k]),
      .quo_o (div_quo[k])
    );
  end

  // Singular flag and pivot translation travel beside the dividers.
  side_t side_q [0:LatDiv-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{sing: (dm_q <= DetLimit), pdu: pdu2_q, pdv: pdv2_q};
      for (int i = 1; i < LatDiv; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Base map selection: inverse, identity or pivot translation.
  logic signed [31:0] base_q [0:5];
  logic               sing_q [0:4];
  side_t              sd;

  assign sd = side_q[LatDiv-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (fix_mode_q && !sd.sing) begin
        for (int i = 0; i < 6; i++) begin
          base_q[i] <= div_quo[i];
        end
      end else begin
        base_q[0] <= One;
        base_q[1] <= '0;
        base_q[2] <= fix_mode_q ? 32'sd0 : sd.pdu;
        base_q[3] <= '0;
        base_q[4] <= One;
        base_q[5] <= fix_mode_q ? 32'sd0 : sd.pdv;
      end
      sing_q[0] <= fix_mode_q && sd.sing;
      for (int i = 1; i < 5; i++) begin
        sing_q[i] <= sing_q[i-1];
      end
    end
  end

  // Scale products.
  logic signed [63:0] sprod_q [0:5];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        sprod_q[i] <= base_q[i] * ((i < 3) ? isx_q : isy_q);
      end
    end
  end

  // Scale shift with saturation, then the texture offset on the constants.
  logic signed [31:0] scl_q [0:5];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        if (i == 2) begin
          scl_q[i] <= sat32(72'(sat32(72'(sprod_q[i] >>> FRAC_BITS))) + 72'(ofs_u_q));
        end else if (i == 5) begin
          scl_q[i] <= sat32(72'(sat32(72'(sprod_q[i] >>> FRAC_BITS))) + 72'(ofs_v_q));
        end else begin
          scl_q[i] <= sat32(72'(sprod_q[i] >>> FRAC_BITS));
        end
      end
    end
  end

  // Move the rotation center to the texture middle.
  logic signed [31:0] hlf_q [0:5];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        if (rot_en_q && ((i == 2) || (i == 5))) begin
          hlf_q[i] <= sat32(72'(scl_q[i]) - 72'(Half));
        end else begin
          hlf_q[i] <= scl_q[i];
        end
      end
    end
  end

  // Rotation products; the unrotated values ride along.
  logic signed [49:0] pcu_q [0:2], psv_q [0:2], psu_q [0:2], pcv_q [0:2];
  logic signed [31:0] pass_q [0:5];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pcu_q[j] <= hlf_q[j] * rcos_q;
        psv_q[j] <= hlf_q[j+3] * rsin_q;
        psu_q[j] <= hlf_q[j] * rsin_q;
        pcv_q[j] <= hlf_q[j+3] * rcos_q;
      end
      for (int i = 0; i < 6; i++) begin
        pass_q[i] <= hlf_q[i];
      end
    end
  end

  // Rotation sums, shift, saturation and the return of the center.
  logic signed [31:0] rot_u [0:2], rot_v [0:2];

  always_comb begin
    logic signed [50:0] su, sv;
    for (int j = 0; j < 3; j++) begin
      su       = 51'(pcu_q[j]) - 51'(psv_q[j]);
      sv       = 51'(psu_q[j]) + 51'(pcv_q[j]);
      rot_u[j] = sat32(72'(su >>> FRAC_BITS));
      rot_v[j] = sat32(72'(sv >>> FRAC_BITS));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (rot_en_q) begin
        u_coef_x_o <= rot_u[0];
        u_coef_y_o <= rot_u[1];
        u_const_o  <= sat32(72'(rot_u[2]) + 72'(Half));
        v_coef_x_o <= rot_v[0];
        v_coef_y_o <= rot_v[1];
        v_const_o  <= sat32(72'(rot_v[2]) + 72'(Half));
      end else begin
        u_coef_x_o <= pass_q[0];
        u_coef_y_o <= pass_q[1];
        u_const_o  <= pass_q[2];
        v_coef_x_o <= pass_q[3];
        v_coef_y_o <= pass_q[4];
        v_const_o  <= pass_q[5];
      end
      singular_o <= sing_q[4];
    end
  end

endmodule

// File: hdl/tuvm_checker.sv
// ----------------------------------------------------------------------------
// tuvm_checker
// Port-level checks of the texture coordinate matrix setup block.
// ----------------------------------------------------------------------------
module tuvm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i
);

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // The input is stalled only while a result is held at the output.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result offered after reset");

endmodule

bind texture_uv_matrix_setup tuvm_checker u_tuvm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

// File: tb/texture_uv_matrix_setup_checker.sv
// ----------------------------------------------------------------------------
// texture_uv_matrix_setup_checker
// Watches both channels and register writes of the texture coordinate setup
// block, predicts each result in fixed point and compares it field by field.
// ----------------------------------------------------------------------------
module texture_uv_matrix_setup_checker
  import tuvm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] mat_a_i,
  input  logic signed [31:0] mat_b_i,
  input  logic signed [31:0] mat_c_i,
  input  logic signed [31:0] mat_d_i,
  input  logic signed [31:0] mat_e_i,
  input  logic signed [31:0] mat_f_i,
  input  logic signed [31:0] spx_i,
  input  logic signed [31:0] spy_i,
  input  logic signed [31:0] lpx_i,
  input  logic signed [31:0] lpy_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] u_coef_x_i,
  input  logic signed [31:0] u_coef_y_i,
  input  logic signed [31:0] u_const_i,
  input  logic signed [31:0] v_coef_x_i,
  input  logic signed [31:0] v_coef_y_i,
  input  logic signed [31:0] v_const_i,
  input  logic               singular_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 singular_seen_o,
  output int                 results_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Fb = 16;

  typedef struct packed {
    logic signed [31:0] ucx, ucy, uk, vcx, vcy, vk;
    logic sing;
  } coef_set_t;

  coef_set_t coef_queue[$];

  // Shadow copy of the block's registers.
  logic               fix_mode_q, rot_en_q;
  logic signed [63:0] scale_x_q, scale_y_q, off_u_q, off_v_q, cos_q, sin_q;

  function automatic logic signed [127:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 128'sd2147483647;
    if (v < -128'sd2147483648) return -128'sd2147483648;
    return v;
  endfunction

  // Arithmetic right shift is a floor shift on signed operands.
  function automatic logic signed [127:0] fmul(input logic signed [127:0] x,
                                               input logic signed [127:0] y);
    return clamp32((x * y) >>> Fb);
  endfunction

  // Signed quotient truncated toward zero of (num << sh) / den, saturated.
  function automatic logic signed [127:0] tdiv(input logic signed [127:0] num,
                                               input int sh,
                                               input logic signed [127:0] den);
    logic [127:0] nm, dm, q;
    logic neg;
    neg = (num < 0) != (den < 0);
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    q = (nm << sh) / dm;
    if (q > 128'h8000_0000) q = 128'h8000_0000;
    return clamp32(neg ? -$signed(q) : $signed(q));
  endfunction

  function automatic coef_set_t predict_coefs(
      input logic signed [127:0] a, b, c, d, e, f, sx, sy, lx, ly);
    logic signed [127:0] m0, m1, m2, m3, m4, m5, det, ua, ub, uc, vd, ve, vf;
    logic signed [127:0] ra, rb, rc, lim, half;
    coef_set_t r;
    half = 128'sd1 <<< (Fb - 1);
    m0 = 128'sd1 <<< Fb; m1 = 0; m2 = 0; m3 = 0; m4 = 128'sd1 <<< Fb; m5 = 0;
    r.sing = 1'b0;
    lim = (128'sd1 <<< (2 * Fb)) / 10000;
    if (fix_mode_q) begin
      det = a * d - b * c;
      if ((det < 0 ? -det : det) > lim) begin
        m0 = tdiv(d, 2 * Fb, det);
        m1 = tdiv(-c, 2 * Fb, det);
        m2 = tdiv(c * f - d * e, Fb, det);
        m3 = tdiv(-b, 2 * Fb, det);
        m4 = tdiv(a, 2 * Fb, det);
        m5 = tdiv(b * e - a * f, Fb, det);
      end else begin
        r.sing = 1'b1;
      end
    end else begin
      m2 = clamp32(lx - sx);
      m5 = clamp32(ly - sy);
    end
    ua = fmul(m0, scale_x_q);
    ub = fmul(m1, scale_x_q);
    uc = clamp32(fmul(m2, scale_x_q) + off_u_q);
    vd = fmul(m3, scale_y_q);
    ve = fmul(m4, scale_y_q);
    vf = clamp32(fmul(m5, scale_y_q) + off_v_q);
    // Rotation about the texture center.
    if (rot_en_q) begin
      uc = clamp32(uc - half);
      vf = clamp32(vf - half);
      ra = clamp32((ua * cos_q - vd * sin_q) >>> Fb);
      rb = clamp32((ub * cos_q - ve * sin_q) >>> Fb);
      rc = clamp32((uc * cos_q - vf * sin_q) >>> Fb);
      vd = clamp32((ua * sin_q + vd * cos_q) >>> Fb);
      ve = clamp32((ub * sin_q + ve * cos_q) >>> Fb);
      vf = clamp32((uc * sin_q + vf * cos_q) >>> Fb);
      ua = ra;
      ub = rb;
      uc = clamp32(rc + half);
      vf = clamp32(vf + half);
    end
    r.ucx = ua[31:0]; r.ucy = ub[31:0]; r.uk = uc[31:0];
    r.vcx = vd[31:0]; r.vcy = ve[31:0]; r.vk = vf[31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Register shadow, request prediction and result comparison.
  always @(posedge clk_i or negedge rst_ni) begin
    coef_set_t w;
    if (!rst_ni) begin
      fix_mode_q <= 1'b0; rot_en_q <= 1'b0;
      scale_x_q <= 64'sd65536; scale_y_q <= 64'sd65536;
      off_u_q <= 0; off_v_q <= 0; cos_q <= 64'sd65536; sin_q <= 0;
      coef_queue.delete();
      fail_count_o = 0;
      singular_seen_o = 0;
      results_seen_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgFixMode:   fix_mode_q <= cfg_wdata_i[0];
          CfgInvScaleX: scale_x_q <= $signed(cfg_wdata_i);
          CfgInvScaleY: scale_y_q <= $signed(cfg_wdata_i);
          CfgOffsetU:   off_u_q <= $signed(cfg_wdata_i);
          CfgOffsetV:   off_v_q <= $signed(cfg_wdata_i);
          CfgRotEnable: rot_en_q <= cfg_wdata_i[0];
          CfgRotCos:    cos_q <= $signed(cfg_wdata_i[17:0]);
          CfgRotSin:    sin_q <= $signed(cfg_wdata_i[17:0]);
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        coef_queue.push_back(predict_coefs(mat_a_i, mat_b_i, mat_c_i, mat_d_i,
                                           mat_e_i, mat_f_i, spx_i, spy_i,
                                           lpx_i, lpy_i));
      end
      if (out_valid_i && !out_stall_i) begin
        results_seen_o++;
        if (coef_queue.size() == 0) begin
          $display("%0t: result with no request outstanding", $realtime);
          fail_count_o++;
        end else begin
          w = coef_queue.pop_front();
          if (w.sing) singular_seen_o++;
          if (u_coef_x_i !== w.ucx) report_mismatch("u_coef_x", u_coef_x_i, w.ucx);
          if (u_coef_y_i !== w.ucy) report_mismatch("u_coef_y", u_coef_y_i, w.ucy);
          if (u_const_i !== w.uk) report_mismatch("u_const", u_const_i, w.uk);
          if (v_coef_x_i !== w.vcx) report_mismatch("v_coef_x", v_coef_x_i, w.vcx);
          if (v_coef_y_i !== w.vcy) report_mismatch("v_coef_y", v_coef_y_i, w.vcy);
          if (v_const_i !== w.vk) report_mismatch("v_const", v_const_i, w.vk);
          if (singular_i !== w.sing) report_mismatch("singular", singular_i, w.sing);
        end
      end
      pending_o = coef_queue.size();
    end
  end

endmodule

// File: tb/texture_uv_matrix_setup_tb.sv
// ----------------------------------------------------------------------------
// texture_uv_matrix_setup_tb
// Drives matrices and pivots into the texture coordinate setup block under
// several register settings and idle patterns; the checker judges results.
// ----------------------------------------------------------------------------
module texture_uv_matrix_setup_tb;
  import tuvm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 20000;
  localparam int Drain = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = CfgFixMode;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic signed [31:0] fld[10] = '{default: '0};
  logic in_stall, out_valid, singular;
  logic signed [31:0] ucx, ucy, uk, vcx, vcy, vk;
  int fails, pending, sing_seen, res_seen;
  int in_idle_pct = 0, out_stall_pct = 0;
  int idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  texture_uv_matrix_setup i_dut (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .mat_a_i(fld[0]), .mat_b_i(fld[1]), .mat_c_i(fld[2]), .mat_d_i(fld[3]),
    .mat_e_i(fld[4]), .mat_f_i(fld[5]), .screen_pivot_x_i(fld[6]),
    .screen_pivot_y_i(fld[7]), .local_pivot_x_i(fld[8]), .local_pivot_y_i(fld[9]),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .u_coef_x_o(ucx), .u_coef_y_o(ucy), .u_const_o(uk), .v_coef_x_o(vcx),
    .v_coef_y_o(vcy), .v_const_o(vk), .singular_o(singular)
  );

  texture_uv_matrix_setup_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .mat_a_i(fld[0]), .mat_b_i(fld[1]), .mat_c_i(fld[2]), .mat_d_i(fld[3]),
    .mat_e_i(fld[4]), .mat_f_i(fld[5]), .spx_i(fld[6]), .spy_i(fld[7]),
    .lpx_i(fld[8]), .lpy_i(fld[9]),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .u_coef_x_i(ucx), .u_coef_y_i(ucy), .u_const_i(uk), .v_coef_x_i(vcx),
    .v_coef_y_i(vcy), .v_const_i(vk), .singular_i(singular),
    .fail_count_o(fails), .pending_o(pending), .singular_seen_o(sing_seen),
    .results_seen_o(res_seen)
  );

  // Receiver stall pattern.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Write enable stays high until the next request or drain lowers it.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  // Wait until every expected result has come, then let the pipe settle.
  task automatic wait_empty();
    in_valid <= 1'b0;
    cfg_we <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  // Present one request, with a random idle gap first, and wait for acceptance.
  // Valid stays high after acceptance so back-to-back requests leave no gap.
  task automatic send_request(input logic [31:0] v[10]);
    cfg_we <= 1'b0;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < in_idle_pct) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    for (int k = 0; k < 10; k++) fld[k] <= v[k];
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Random 32-bit value biased toward magnitudes near one in Q16.16.
  function automatic logic [31:0] rand_q();
    case ($urandom_range(5))
      0: return $urandom();
      1: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
      2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
    endcase
  endfunction

  task automatic send_random(input int n);
    logic [31:0] v[10];
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 10; k++) v[k] = rand_q();
      // Some near-singular matrices: rows nearly proportional.
      if ($urandom_range(9) == 0) begin
        v[2] = v[0];
        v[3] = v[1] + $urandom_range(3);
      end
      send_request(v);
    end
  endtask

  task automatic random_setting();
    write_reg(CfgFixMode, $urandom_range(1));
    write_reg(CfgInvScaleX, $urandom_range(3) == 0 ? $urandom() : $urandom_range(4 << 16));
    write_reg(CfgInvScaleY, $urandom_range(3) == 0 ? $urandom() : $urandom_range(4 << 16));
    write_reg(CfgOffsetU, rand_q());
    write_reg(CfgOffsetV, rand_q());
    write_reg(CfgRotEnable, $urandom_range(1));
    write_reg(CfgRotCos, 32'($signed($urandom_range(131072)) - 65536));
    write_reg(CfgRotSin, $urandom_range(7) == 0 ? $urandom() :
                         32'($signed($urandom_range(131072)) - 65536));
  endtask

  initial begin
    logic [31:0] v[10];
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: defaults, pivot mode with extreme pivots.
    v = '{default: 32'h0};
    send_request(v);
    v = '{32'h10000, 0, 0, 32'h10000, 0, 0, 32'h7fff_ffff, 32'h8000_0000,
          32'h8000_0000, 32'h7fff_ffff};
    send_request(v);
    v = '{default: 32'hffff_ffff};
    send_request(v);
    wait_empty();

    // Directed: fixed mode, identity, singular, tiny and huge determinants.
    write_reg(CfgFixMode, 1);
    v = '{32'h10000, 0, 0, 32'h10000, 32'h30000, 32'hfffe0000, 0, 0, 0, 0};
    send_request(v);
    v = '{default: 32'h0};
    send_request(v);
    v = '{32'h2, 0, 0, 32'h2, 0, 0, 0, 0, 0, 0};
    send_request(v);
    v = '{32'h7fff_ffff, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0};
    send_request(v);
    v = '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
          32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0};
    send_request(v);
    v = '{0, 32'h10000, 32'hffff0000, 0, 32'h12345, 32'hedcba, 0, 0, 0, 0};
    send_request(v);
    v = '{32'h1a, 32'h0, 32'h0, 32'h1a, 0, 0, 0, 0, 0, 0};
    send_request(v);
    v = '{32'h1, 32'h0, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h1, 0, 0, 0, 0};
    send_request(v);
    wait_empty();

    // Directed: extreme scales, offsets and out-of-range trig values.
    write_reg(CfgInvScaleX, 32'h7fff_ffff);
    write_reg(CfgInvScaleY, 32'h8000_0000);
    write_reg(CfgOffsetU, 32'h7fff_ffff);
    write_reg(CfgOffsetV, 32'h8000_0000);
    write_reg(CfgRotEnable, 1);
    write_reg(CfgRotCos, 32'h0001_ffff);
    write_reg(CfgRotSin, 32'h0002_0000);
    write_reg(4'd9, 32'hffff_ffff);
    v = '{32'h10000, 32'h8000, 32'hffff8000, 32'h20000, 32'h7fff_ffff, 32'h8000_0000,
          0, 0, 0, 0};
    send_request(v);
    v = '{default: 32'h0};
    send_request(v);
    wait_empty();
    write_reg(CfgFixMode, 0);
    v = '{0, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
    send_request(v);
    wait_empty();

    // Random phases across idle patterns and register settings.
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin in_idle_pct = 0; out_stall_pct = 0; end
        1: begin in_idle_pct = 74; out_stall_pct = 0; end
        2: begin in_idle_pct = 0; out_stall_pct = 74; end
        default: begin in_idle_pct = 10; out_stall_pct = 10; end
      endcase
      random_setting();
      send_random(115);
      wait_empty();
    end

    in_idle_pct = 0;
    out_stall_pct = 0;
    wait_empty();
    $display("Ran %0d results through pivot and inverse modes, %0d singular,",
             res_seen, sing_seen);
    $display("under random register settings and four idle patterns.");
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
